>>> rtl/core/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned KEY_W     = 2;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CNT_W-1:0] TRIPLE_CLICKS = CNT_W'(3);

  typedef enum logic [CODE_W-1:0] {
    EV_SINGLE = 3'd0,
    EV_DOUBLE = 3'd1,
    EV_TRIPLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_DOWN   = 3'd4,
    EV_END    = 3'd5
  } event_code_e;

  typedef enum logic [1:0] {
    REG_SHORT_TIMEOUT  = 2'd0,
    REG_LONG_TIMEOUT   = 2'd1,
    REG_DURATION_LIMIT = 2'd2,
    REG_TRIPLE_UPDOWN  = 2'd3
  } reg_index_e;

  localparam logic [DUR_W-1:0] SHORT_TIMEOUT_RST  = DUR_W'(30);
  localparam logic [DUR_W-1:0] LONG_TIMEOUT_RST   = DUR_W'(100);
  localparam logic [DUR_W-1:0] DURATION_LIMIT_RST = DUR_W'(65535);

  typedef struct packed {
    logic [DUR_W-1:0] short_timeout;
    logic [DUR_W-1:0] long_timeout;
    logic [DUR_W-1:0] duration_limit;
    logic             triple_updown;
  } cfg_t;

  typedef struct packed {
    logic             last_level;
    logic             updown;
    logic             suppress;
    logic [CNT_W-1:0] clicks;
    logic [DUR_W-1:0] duration;
  } key_state_t;

endpackage

>>> rtl/core/bcc_if.sv
// ----------------------------------------------------------------------------
// bcc_sample_if / bcc_event_if
// Valid/ready channels for key samples and classified events.
// ----------------------------------------------------------------------------
interface bcc_sample_if import bcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_index;
  logic             pressed;

  modport source (output valid, output key_index, output pressed, input ready);
  modport sink   (input valid, input key_index, input pressed, output ready);
endinterface

interface bcc_event_if import bcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  event_key;
  logic [CODE_W-1:0] event_code;

  modport source (output valid, output event_key, output event_code, input ready);
  modport sink   (input valid, input event_key, input event_code, output ready);
endinterface

>>> rtl/core/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// APB register file holding timeouts, duration limit and triple option.
// ----------------------------------------------------------------------------
module bcc_cfg_regs import bcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  reg_index_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_timeout  <= SHORT_TIMEOUT_RST;
      cfg_q.long_timeout   <= LONG_TIMEOUT_RST;
      cfg_q.duration_limit <= DURATION_LIMIT_RST;
      cfg_q.triple_updown  <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_SHORT_TIMEOUT:  cfg_q.short_timeout  <= pwdata[DUR_W-1:0];
        REG_LONG_TIMEOUT:   cfg_q.long_timeout   <= pwdata[DUR_W-1:0];
        REG_DURATION_LIMIT: cfg_q.duration_limit <= pwdata[DUR_W-1:0];
        REG_TRIPLE_UPDOWN:  cfg_q.triple_updown  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SHORT_TIMEOUT:  prdata = APB_DW'(cfg_q.short_timeout);
      REG_LONG_TIMEOUT:   prdata = APB_DW'(cfg_q.long_timeout);
      REG_DURATION_LIMIT: prdata = APB_DW'(cfg_q.duration_limit);
      REG_TRIPLE_UPDOWN:  prdata = APB_DW'(cfg_q.triple_updown);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/bcc_key_engine.sv
// ----------------------------------------------------------------------------
// bcc_key_engine
// Per-key state store and the single-pass click classification logic.
// ----------------------------------------------------------------------------
module bcc_key_engine import bcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              fire_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic              pressed_i,
  output logic              have_o,
  output event_code_e       code_o
);

  key_state_t state_q [NUM_KEYS];
  key_state_t cur;
  key_state_t nxt;
  logic       key_ok;
  logic       have;
  event_code_e code;

  assign key_ok = ({1'b0, key_i} < (KEY_W+1)'(NUM_KEYS));
  assign cur    = state_q[key_i];

  always_comb begin
    nxt  = cur;
    have = 1'b0;
    code = EV_SINGLE;
    if (cur.updown) begin
      if (pressed_i) begin
        have = 1'b1;
        code = EV_DOWN;
      end else if (cur.last_level) begin
        nxt.updown   = 1'b0;
        nxt.suppress = 1'b0;
        nxt.clicks   = '0;
        nxt.duration = '0;
        have         = 1'b1;
        code         = EV_END;
      end
    end else begin
      if (cur.last_level != pressed_i) begin
        nxt.duration = DUR_W'(1);
        if (!pressed_i) begin
          if (cur.suppress) begin
            // release after a long click is swallowed
            nxt.suppress = 1'b0;
            nxt.duration = '0;
          end else if (cur.clicks < TRIPLE_CLICKS) begin
            nxt.clicks = cur.clicks + CNT_W'(1);
          end
        end
      end else if (cur.duration != '0 && cur.duration < cfg_i.duration_limit) begin
        nxt.duration = cur.duration + DUR_W'(1);
      end

      if (nxt.clicks == TRIPLE_CLICKS) begin
        nxt.clicks   = '0;
        nxt.duration = '0;
        have         = 1'b1;
        code         = EV_TRIPLE;
        if (cfg_i.triple_updown) begin
          nxt.updown   = 1'b1;
          nxt.suppress = 1'b0;
        end
      end else if (nxt.duration > cfg_i.short_timeout && !pressed_i) begin
        code         = (nxt.clicks == CNT_W'(2)) ? EV_DOUBLE : EV_SINGLE;
        nxt.clicks   = '0;
        nxt.duration = '0;
        have         = 1'b1;
      end else if (nxt.duration > cfg_i.long_timeout && pressed_i) begin
        nxt.clicks   = '0;
        nxt.duration = '0;
        nxt.suppress = 1'b1;
        have         = 1'b1;
        code         = EV_LONG;
      end
    end
    nxt.last_level = pressed_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        state_q[i] <= '0;
      end
    end else if (fire_i && key_ok) begin
      state_q[key_i] <= nxt;
    end
  end

  assign have_o = have && key_ok;
  assign code_o = code;

  // a key in up-down mode never carries a pending long-click suppress
  a_updown_no_suppress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && nxt.updown |-> !nxt.suppress)
    else $error("up-down key with suppress set");

  // a stored click count never reaches three
  a_clicks_below_triple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> nxt.clicks != TRIPLE_CLICKS)
    else $error("click count stored at triple");

  // a long click arms the suppress flag of its key
  a_long_sets_suppress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && have_o && code == EV_LONG |=> state_q[$past(key_i)].suppress)
    else $error("long click without suppress");

  // an up-down key whose level stays released raises no event
  a_updown_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && cur.updown && !pressed_i && !cur.last_level |-> !have)
    else $error("event from idle up-down key");

endmodule

>>> rtl/core/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier
// Classifies per-key polling samples into click, long, held and end events.
// ----------------------------------------------------------------------------
// Usage: sample_i carries one polling tick per item (key_index, pressed).
// event_o carries at most one event per sample (event_key, event_code).
// Timeouts, duration limit and the triple-into-up-down option sit behind
// the APB port at byte addresses 0x0, 0x4, 0x8 and 0xC; write them only
// while no sample is in flight.
// Throughput: one sample per cycle, for any mix of keys, while event_o is
// not held. The per-key state is read for the sample in the input register
// and written back as it moves on, so a following sample of the same key
// sees the updated state. Each event is held in the output register that
// drives event_o, loaded as its sample leaves the input register.
// Reset: all keys return to click mode with empty logs, registers to their
// defaults (30, 100, 65535, 0), both pipeline registers empty.
// Stall: while event_o is held, one more sample is taken into the input
// register and then sample_i.ready drops until the event is taken.
// ----------------------------------------------------------------------------
module button_click_classifier import bcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcc_sample_if.sink        sample_i,
  bcc_event_if.source       event_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg;
  logic             in_vld_q;
  logic [KEY_W-1:0] in_key_q;
  logic             in_prs_q;
  logic             out_vld_q;
  logic [KEY_W-1:0] out_key_q;
  event_code_e      out_code_q;
  logic             advance;
  logic             fire;
  logic             have;
  event_code_e      code;

  bcc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance        = !out_vld_q || event_o.ready;
  assign fire           = in_vld_q && advance;
  assign sample_i.ready = !in_vld_q || advance;

  bcc_key_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (fire),
    .key_i     (in_key_q),
    .pressed_i (in_prs_q),
    .have_o    (have),
    .code_o    (code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        in_vld_q <= sample_i.valid;
      end
      if (advance) begin
        out_vld_q <= fire && have;
      end
    end
  end

  // hold payloads until their stage moves
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_key_q <= sample_i.key_index;
      in_prs_q <= sample_i.pressed;
    end
    if (fire && have && advance) begin
      out_key_q  <= in_key_q;
      out_code_q <= code;
    end
  end

  assign event_o.valid      = out_vld_q;
  assign event_o.event_key  = out_key_q;
  assign event_o.event_code = out_code_q;

endmodule

>>> bench/button_click_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_click_classifier_tb
// Drives per-key polling ticks into the classifier and checks every event
// against a cycle-free model of the per-key click logic. A short table of
// hand-checked ticks comes first, then a stall phase, then randomized click
// scripts under several timeout settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module button_click_classifier_tb;
  import bcc_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PLAN_DEPTH     = 256;

  typedef struct {
    logic [KEY_W-1:0] key;
    event_code_e      code;
  } click_event_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             lvl;
    bit               typed;
    bit               fires;
    event_code_e      code;
  } tick_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bcc_sample_if smp_if ();
  bcc_event_if  ev_if ();

  button_click_classifier dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .event_o  (ev_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Model state: settings and per-key click log
  cfg_t         cfg;
  key_state_t   keys [NUM_KEYS];
  click_event_t pending_events [$];
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  bit           hold_req;
  bit           send_burst;
  bit           take_burst;

  // Per-key level scripts for the random part
  bit [PLAN_DEPTH-1:0] plan [NUM_KEYS];
  int unsigned         plan_len [NUM_KEYS];
  int unsigned         plan_pos [NUM_KEYS];

  // Timeouts for this table: short 1, long 2, triple enters up-down
  tick_row_t directed_ticks [24] = '{
    '{2'd0, 1'b1, 1'b1, 1'b0, EV_SINGLE},
    '{2'd0, 1'b0, 1'b0, 1'b0, EV_SINGLE},
    '{2'd0, 1'b0, 1'b1, 1'b1, EV_SINGLE},
    '{2'd3, 1'b1, 1'b0, 1'b0, EV_SINGLE},
    '{2'd3, 1'b0, 1'b0, 1'b0, EV_SINGLE},
    '{2'd3, 1'b1, 1'b0, 1'b0, EV_SINGLE},
    '{2'd3, 1'b0, 1'b0, 1'b0, EV_SINGLE},
    '{2'd3, 1'b0, 1'b1, 1'b1, EV_DOUBLE},
    '{2'd1, 1'b1, 1'b0, 1'b0, EV_SINGLE},
    '{2'd1, 1'b1, 1'b0, 1'b0, EV_SINGLE},
    '{2'd1, 1'b1, 1'b1, 1'b1, EV_LONG},
    '{2'd1, 1'b1, 1'b1, 1'b0, EV_SINGLE},
    // release after a long click is swallowed
    '{2'd1, 1'b0, 1'b1, 1'b0, EV_SINGLE},
    '{2'd1, 1'b0, 1'b0, 1'b0, EV_SINGLE},
    '{2'd2, 1'b1, 1'b0, 1'b0, EV_SINGLE},
    '{2'd2, 1'b0, 1'b0, 1'b0, EV_SINGLE},
    '{2'd2, 1'b1, 1'b0, 1'b0, EV_SINGLE},
    '{2'd2, 1'b0, 1'b0, 1'b0, EV_SINGLE},
    '{2'd2, 1'b1, 1'b0, 1'b0, EV_SINGLE},
    '{2'd2, 1'b0, 1'b1, 1'b1, EV_TRIPLE},
    '{2'd2, 1'b1, 1'b1, 1'b1, EV_DOWN},
    '{2'd2, 1'b1, 1'b1, 1'b1, EV_DOWN},
    '{2'd2, 1'b0, 1'b1, 1'b1, EV_END},
    // released ticks after the end stay silent
    '{2'd2, 1'b0, 1'b1, 1'b0, EV_SINGLE}
  };

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Advance one key's click log by one tick and report the event it raises.
  function automatic void classify_tick(input logic [KEY_W-1:0] k, input logic lvl,
                                        output bit fired, output event_code_e code);
    key_state_t ks;
    ks    = keys[k];
    fired = 1'b0;
    code  = EV_SINGLE;
    if (ks.updown) begin
      if (lvl) begin
        fired = 1'b1;
        code  = EV_DOWN;
      end else if (ks.last_level) begin
        ks.updown   = 1'b0;
        ks.suppress = 1'b0;
        ks.clicks   = '0;
        ks.duration = '0;
        fired       = 1'b1;
        code        = EV_END;
      end
    end else begin
      if (ks.last_level != lvl) begin
        ks.duration = DUR_W'(1);
        if (!lvl) begin
          if (ks.suppress) begin
            ks.suppress = 1'b0;
            ks.duration = '0;
          end else if (ks.clicks < TRIPLE_CLICKS) begin
            ks.clicks = ks.clicks + CNT_W'(1);
          end
        end
      end else if (ks.duration != '0 && ks.duration < cfg.duration_limit) begin
        ks.duration = ks.duration + DUR_W'(1);
      end

      if (ks.clicks == TRIPLE_CLICKS) begin
        ks.clicks   = '0;
        ks.duration = '0;
        fired       = 1'b1;
        code        = EV_TRIPLE;
        if (cfg.triple_updown) begin
          ks.updown   = 1'b1;
          ks.suppress = 1'b0;
        end
      end else if (!lvl && ks.duration > cfg.short_timeout) begin
        code        = (ks.clicks == CNT_W'(2)) ? EV_DOUBLE : EV_SINGLE;
        ks.clicks   = '0;
        ks.duration = '0;
        fired       = 1'b1;
      end else if (lvl && ks.duration > cfg.long_timeout) begin
        ks.clicks   = '0;
        ks.duration = '0;
        ks.suppress = 1'b1;
        fired       = 1'b1;
        code        = EV_LONG;
      end
    end
    ks.last_level = lvl;
    keys[k]       = ks;
  endfunction

  function automatic int unsigned span(input int unsigned t, input int unsigned hi);
    return (t < 1) ? 1 : ((t > hi) ? hi : t);
  endfunction

  task automatic write_reg(input reg_index_e idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SHORT_TIMEOUT:  cfg.short_timeout  = val[DUR_W-1:0];
      REG_LONG_TIMEOUT:   cfg.long_timeout   = val[DUR_W-1:0];
      REG_DURATION_LIMIT: cfg.duration_limit = val[DUR_W-1:0];
      REG_TRIPLE_UPDOWN:  cfg.triple_updown  = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [DUR_W-1:0] short_t, input logic [DUR_W-1:0] long_t,
                            input logic [DUR_W-1:0] limit, input logic triple);
    write_reg(REG_SHORT_TIMEOUT, APB_DW'(short_t));
    write_reg(REG_LONG_TIMEOUT, APB_DW'(long_t));
    write_reg(REG_DURATION_LIMIT, APB_DW'(limit));
    write_reg(REG_TRIPLE_UPDOWN, APB_DW'(triple));
  endtask

  // Offer one tick, wait for it to be taken, then log what it should raise.
  task automatic send_tick(input logic [KEY_W-1:0] k, input logic lvl, input bit typed,
                           input bit exp_fires, input event_code_e exp_code);
    int unsigned gap;
    bit          fired;
    event_code_e code;
    if ($urandom_range(0, 31) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid     <= 1'b1;
    smp_if.key_index <= k;
    smp_if.pressed   <= lvl;
    do @(posedge clk_i); while (!smp_if.ready);
    classify_tick(k, lvl, fired, code);
    if (typed) begin
      fired = exp_fires;
      code  = exp_code;
    end
    if (fired) pending_events.push_back('{key: k, code: code});
  endtask

  // Drop valid, wait out all events and the ticks still in the pipeline.
  task automatic settle();
    smp_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_levels(input int unsigned k, input bit lvl, input int unsigned len);
    repeat (len) begin
      plan[k][plan_len[k]] = lvl;
      plan_len[k]++;
    end
  endtask

  // Script a click burst, a long press or a bit of chatter for one key.
  task automatic build_plan(input int unsigned k);
    int unsigned style;
    plan_len[k] = 0;
    plan_pos[k] = 0;
    style = $urandom_range(0, 9);
    if (style < 6) begin
      repeat ($urandom_range(1, 4)) begin
        push_levels(k, 1'b1, $urandom_range(1, span(cfg.long_timeout, 12)));
        push_levels(k, 1'b0, $urandom_range(1, span(cfg.short_timeout, 12)));
      end
      push_levels(k, 1'b0, $urandom_range(1, span(cfg.short_timeout, 40) + 4));
    end else if (style < 8) begin
      push_levels(k, 1'b1, span(cfg.long_timeout, 104) + $urandom_range(0, 3));
      push_levels(k, 1'b0, $urandom_range(1, 6));
    end else begin
      repeat ($urandom_range(1, 8)) push_levels(k, 1'($urandom_range(0, 1)), 1);
    end
  endtask

  task automatic run_click_phase(input logic [DUR_W-1:0] short_t,
                                 input logic [DUR_W-1:0] long_t,
                                 input logic [DUR_W-1:0] limit, input logic triple,
                                 input int unsigned n_ticks);
    int unsigned k;
    settle();
    set_timing(short_t, long_t, limit, triple);
    repeat (n_ticks) begin
      k = $urandom_range(0, NUM_KEYS - 1);
      if (plan_pos[k] >= plan_len[k]) build_plan(k);
      send_tick(KEY_W'(k), plan[k][plan_pos[k]], 1'b0, 1'b0, EV_SINGLE);
      plan_pos[k]++;
    end
  endtask

  // Event side: random stalls, burst stretches, one long hold-off on request.
  initial begin : event_drain
    int unsigned stall;
    ev_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        ev_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) take_burst = ~take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        ev_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ev_if.ready <= 1'b1;
      do @(posedge clk_i); while (!ev_if.valid);
    end
  end

  always @(posedge clk_i) begin : event_check
    click_event_t want;
    if (rst_ni && ev_if.valid && ev_if.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, got key %0d code %0d",
                 $time, ev_if.event_key, ev_if.event_code);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (want.key !== ev_if.event_key) begin
          $display("%0t: event_key mismatch, expected %0d, got %0d",
                   $time, want.key, ev_if.event_key);
          mismatches++;
        end
        if (want.code !== ev_if.event_code) begin
          $display("%0t: event_code mismatch, expected %0d, got %0d",
                   $time, want.code, ev_if.event_code);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (ev_if.valid && ev_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("button_click_classifier verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned i;
    hold_req     = 1'b0;
    send_burst   = 1'b0;
    cfg          = '{short_timeout: SHORT_TIMEOUT_RST, long_timeout: LONG_TIMEOUT_RST,
                     duration_limit: DURATION_LIMIT_RST, triple_updown: 1'b0};
    for (i = 0; i < NUM_KEYS; i++) begin
      keys[i]     = '0;
      plan[i]     = '0;
      plan_len[i] = 0;
      plan_pos[i] = 0;
    end
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    smp_if.valid     <= 1'b0;
    smp_if.key_index <= '0;
    smp_if.pressed   <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_timing(DUR_W'(1), DUR_W'(2), DURATION_LIMIT_RST, 1'b1);
    foreach (directed_ticks[r]) begin
      send_tick(directed_ticks[r].key, directed_ticks[r].lvl, directed_ticks[r].typed,
                directed_ticks[r].fires, directed_ticks[r].code);
    end

    // Put key 0 into up-down mode, then hold events off while it keeps firing
    settle();
    set_timing(DUR_W'(2), DUR_W'(5), DURATION_LIMIT_RST, 1'b1);
    repeat (3) begin
      send_tick(KEY_W'(0), 1'b1, 1'b0, 1'b0, EV_SINGLE);
      send_tick(KEY_W'(0), 1'b0, 1'b0, 1'b0, EV_SINGLE);
    end
    hold_req = 1'b1;
    repeat (40) send_tick(KEY_W'(0), 1'b1, 1'b0, 1'b0, EV_SINGLE);
    send_tick(KEY_W'(0), 1'b0, 1'b0, 1'b0, EV_SINGLE);

    run_click_phase(DUR_W'(0), DUR_W'(0), DURATION_LIMIT_RST, 1'b0, 250);
    run_click_phase(DUR_W'(65535), DUR_W'(65535), DURATION_LIMIT_RST, 1'b1, 200);
    run_click_phase(DUR_W'(0), DUR_W'(3), DUR_W'(1), 1'b0, 250);
    run_click_phase(SHORT_TIMEOUT_RST, LONG_TIMEOUT_RST, DURATION_LIMIT_RST, 1'b0, 300);
    repeat (3) begin
      run_click_phase(DUR_W'($urandom_range(0, 8)), DUR_W'($urandom_range(0, 12)),
                      $urandom_range(0, 1) ? DURATION_LIMIT_RST : DUR_W'($urandom_range(1, 14)),
                      1'($urandom_range(0, 1)), 250);
    end

    settle();
    if (mismatches == 0) begin
      $display("button_click_classifier verification clean");
    end else begin
      $display("button_click_classifier verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/bcc_pkg.sv
rtl/core/bcc_if.sv
rtl/core/bcc_cfg_regs.sv
rtl/core/bcc_key_engine.sv
rtl/core/button_click_classifier.sv
bench/button_click_classifier_tb.sv
